FILE: design/eaut_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the encoder angle unwrap tracker.
// No dependencies; every other file of the block but eaut_table_ram imports this package.
package eaut_pkg;

	localparam int POSITION_BITS = 14;
	localparam int RAW_POS_W     = 14;
	localparam int WORD_W        = 16;
	localparam int ANGLE_W       = 25;
	localparam int DIFF_W        = ANGLE_W + 1;
	localparam int ACC_W         = 48;
	localparam int S_TDATA_W     = 56;
	localparam int M_TDATA_W     = 112;

	// Degrees with 16 fraction bits.
	localparam int HALF_TURN_VAL = 11796480;
	localparam int FULL_TURN_VAL = 23592960;

	localparam logic signed [DIFF_W-1:0] HALF_TURN     = DIFF_W'(HALF_TURN_VAL);
	localparam logic signed [DIFF_W-1:0] NEG_HALF_TURN = -DIFF_W'(HALF_TURN_VAL);
	localparam logic signed [DIFF_W-1:0] FULL_TURN     = DIFF_W'(FULL_TURN_VAL);

	typedef enum logic {
		OP_TABLE_WRITE = 1'b0,
		OP_RESPONSE    = 1'b1
	} op_t;

	typedef logic [POSITION_BITS-1:0] pos_t;
	typedef logic [ANGLE_W-1:0]       angle_t;
	typedef logic signed [DIFF_W-1:0] diff_t;
	typedef logic signed [ACC_W-1:0]  acc_t;

	typedef struct packed {
		logic                 parity_error;
		logic [RAW_POS_W-1:0] raw_position;
	} tag_t;

	typedef struct packed {
		tag_t  tag;
		diff_t diff;
	} unwrap_t;

endpackage

FILE: design/eaut_table_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module eaut_table_ram #(
	parameter int ADDR_W = 14,
	parameter int DATA_W = 25
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [2**ADDR_W];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: design/eaut_unwrap.sv
`timescale 1ns / 1ps
// Unwrap stage: difference from the previous looked-up angle, folded into +-180 degrees.
// Depends on eaut_pkg.
module eaut_unwrap import eaut_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  angle_t  in_angle,
	input  tag_t    in_tag,
	output logic    out_valid,
	input  logic    out_ready,
	output unwrap_t out_data
);

	angle_t  last_q;
	logic    valid_s2;
	unwrap_t data_s2;
	diff_t   step_diff;
	diff_t   wrapped;

	assign in_ready = !valid_s2 || out_ready;

	// All three candidates exist in parallel; the compare on the raw difference picks one.
	always_comb begin
		step_diff = $signed({1'b0, in_angle}) - $signed({1'b0, last_q});
		if (step_diff < NEG_HALF_TURN) begin
			wrapped = step_diff + FULL_TURN;
		end else if (step_diff > HALF_TURN) begin
			wrapped = step_diff - FULL_TURN;
		end else begin
			wrapped = step_diff;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			last_q   <= '0;
		end else if (in_ready) begin
			valid_s2 <= in_valid;
			if (in_valid) begin
				last_q <= in_angle;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s2.tag  <= in_tag;
			data_s2.diff <= wrapped;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = data_s2;

endmodule

FILE: design/eaut_accum.sv
`timescale 1ns / 1ps
// Multi-turn accumulator and output register of the tracker.
// Depends on eaut_pkg.
module eaut_accum import eaut_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  unwrap_t              in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output tag_t                 out_tag,
	output acc_t                 out_accumulated,
	output acc_t                 out_prior
);

	acc_t running_q;
	acc_t next_running;
	logic out_valid_q;
	tag_t tag_q;
	acc_t acc_q;
	acc_t prior_q;

	assign in_ready = !out_valid_q || out_ready;

	assign next_running = running_q
		+ {{(ACC_W-DIFF_W){in_data.diff[DIFF_W-1]}}, in_data.diff};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			running_q   <= '0;
		end else if (in_ready) begin
			out_valid_q <= in_valid;
			if (in_valid) begin
				running_q <= next_running;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			tag_q   <= in_data.tag;
			acc_q   <= next_running;
			prior_q <= running_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign out_tag         = tag_q;
	assign out_accumulated = acc_q;
	assign out_prior       = prior_q;

endmodule

FILE: design/encoder_angle_unwrap_tracker.sv
`timescale 1ns / 1ps
// Top level of the encoder angle unwrap tracker.
// Depends on eaut_pkg, eaut_table_ram, eaut_unwrap and eaut_accum.
//
// Channel  Dir  Transaction
// s_*      in   table write (s_tuser = 0) or sensor response (s_tuser = 1)
// m_*      out  one result per sensor response; table writes give none
//
// Throughput is one transaction per cycle on both sides, table writes included, while m_tready holds no result back.
// A response reaches m_tvalid through the table read register, taken at the edge that accepts it,
// then the unwrap register and then the output register.
// Reset clears the valid bits, the last looked-up angle and the accumulator, not the table.
// Each stage holds while the one after it is full and stalled, so a bubble anywhere
// lets s_tready stay high even while a result waits on m_tready.
module encoder_angle_unwrap_tracker import eaut_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// [13:0] table_index, [38:14] table_angle, [54:39] response_word, [55] zero
	input  logic [S_TDATA_W-1:0] s_tdata,
	// [0] operation
	input  logic [0:0]           s_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// [13:0] raw_position, [61:14] accumulated_angle, [109:62] prior_angle, [111:110] zero
	output logic [M_TDATA_W-1:0] m_tdata,
	// [0] parity_error
	output logic [0:0]           m_tuser
);

	// Input unpacking.
	op_t                 operation;
	logic [RAW_POS_W-1:0] table_index;
	angle_t              table_angle;
	logic [WORD_W-1:0]   response_word;

	assign operation     = op_t'(s_tuser[0]);
	assign table_index   = s_tdata[13:0];
	assign table_angle   = s_tdata[38:14];
	assign response_word = s_tdata[54:39];

	// Accept stage: table writes go straight into the RAM; responses are parity checked
	// and issue the table read. A write always lands at an edge before any later read
	// is issued, so the RAM needs no bypass path.
	logic    accept;
	logic    wr_en;
	logic    rd_en;
	logic    parity_error;
	pos_t    position;
	pos_t    write_addr;
	angle_t  looked_angle;

	assign accept       = s_tvalid && s_tready;
	assign wr_en        = accept && (operation == OP_TABLE_WRITE);
	assign rd_en        = accept && (operation == OP_RESPONSE);
	assign parity_error = ^response_word;
	assign position     = parity_error ? '0 : response_word[POSITION_BITS-1:0];
	assign write_addr   = POSITION_BITS'(table_index);

	eaut_table_ram #(
		.ADDR_W (POSITION_BITS),
		.DATA_W (ANGLE_W)
	) u_table_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (write_addr),
		.wdata (table_angle),
		.re    (rd_en),
		.raddr (position),
		.rdata (looked_angle)
	);

	// Stage 1 tracks the RAM read data. The RAM output only changes on a new read,
	// and no read is issued while stage 1 is held, so it stays stable during a stall.
	logic    valid_s1;
	tag_t    tag_s1;
	logic    ready_s2;

	assign s_tready = !valid_s1 || ready_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= rd_en;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			tag_s1.parity_error <= parity_error;
			tag_s1.raw_position <= RAW_POS_W'(position);
		end
	end

	// Stage 2: wrapped difference against the previous looked-up angle.
	logic    valid_s2;
	logic    ready_out;
	unwrap_t unwrap_s2;

	eaut_unwrap u_unwrap (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s1),
		.in_ready  (ready_s2),
		.in_angle  (looked_angle),
		.in_tag    (tag_s1),
		.out_valid (valid_s2),
		.out_ready (ready_out),
		.out_data  (unwrap_s2)
	);

	// Stage 3: accumulate and hold the result for the output transaction.
	tag_t result_tag;
	acc_t accumulated_angle;
	acc_t prior_angle;

	eaut_accum u_accum (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (valid_s2),
		.in_ready        (ready_out),
		.in_data         (unwrap_s2),
		.out_valid       (m_tvalid),
		.out_ready       (m_tready),
		.out_tag         (result_tag),
		.out_accumulated (accumulated_angle),
		.out_prior       (prior_angle)
	);

	assign m_tdata = {2'b00, prior_angle, accumulated_angle, result_tag.raw_position};
	assign m_tuser = result_tag.parity_error;

endmodule

FILE: design/eaut_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the encoder angle unwrap tracker, bound to the top level.
// Depends on eaut_pkg and encoder_angle_unwrap_tracker.
module eaut_checker import eaut_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata,
	input logic [0:0]           m_tuser
);

	acc_t last_acc_q;
	acc_t step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_acc_q <= '0;
		end else if (m_tvalid && m_tready) begin
			last_acc_q <= m_tdata[61:14];
		end
	end

	assign step = $signed(m_tdata[61:14]) - $signed(m_tdata[109:62]);

	// A stalled result must not change.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// Results chain: each prior angle is the accumulated angle of the result before it.
	a_chain: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[109:62] == last_acc_q)
		else $error("prior angle does not match previous result");

	// A parity failure always reports position zero.
	a_parity: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[13:0] == '0)
		else $error("nonzero position on parity error");

	// The wrapped step never exceeds half a turn in either direction.
	a_step: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (step <= $signed(ACC_W'(HALF_TURN_VAL)))
			&& (step >= -$signed(ACC_W'(HALF_TURN_VAL))))
		else $error("angle step beyond half a turn");

endmodule

bind encoder_angle_unwrap_tracker eaut_checker u_eaut_checker (.*);
